// ===== hdl/bfic_pkg.sv =====
// Shared sizes, instruction and status codes, register map and byte decoder.
package bfic_pkg;

    // Storage depths
    localparam int PROG_DEPTH = 1024;
    localparam int TAPE_DEPTH = 1024;
    localparam int NEST_DEPTH = 64;

    // Derived widths
    localparam int PA_W = $clog2(PROG_DEPTH);      // program store index
    localparam int PC_W = $clog2(PROG_DEPTH + 1);  // counter that can hold PROG_DEPTH
    localparam int TA_W = $clog2(TAPE_DEPTH);      // tape index
    localparam int SA_W = $clog2(NEST_DEPTH);      // bracket stack index
    localparam int SD_W = $clog2(NEST_DEPTH + 1);  // stack depth counter

    // Register file
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_CELL_MIN = 1'b0;
    localparam logic REG_CELL_MAX = 1'b1;
    localparam logic [7:0] CELL_MIN_RST = 8'h00;
    localparam logic [7:0] CELL_MAX_RST = 8'hFF;

    // Source characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;

    typedef enum logic [2:0] {
        OP_INC   = 3'd0,
        OP_DEC   = 3'd1,
        OP_LEFT  = 3'd2,
        OP_RIGHT = 3'd3,
        OP_OUT   = 3'd4,
        OP_IN    = 3'd5,
        OP_OPEN  = 3'd6,
        OP_CLOSE = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_FULL            = 3'd1,
        ST_UNMATCHED_CLOSE = 3'd2,
        ST_NEST_OVERFLOW   = 3'd3,
        ST_UNMATCHED_OPEN  = 3'd4,
        ST_HALTED          = 3'd5
    } status_t;

    // Item kinds on the input channel
    localparam logic ITEM_LOAD = 1'b0;
    localparam logic ITEM_STEP = 1'b1;

    typedef struct packed {
        logic hit;
        op_t  code;
    } decode_t;

    typedef struct packed {
        logic [7:0] cell_min;
        logic [7:0] cell_max;
    } cell_bounds_t;

    // Map a source byte to an instruction code; hit is low for comment bytes
    function automatic decode_t decode_byte(input logic [7:0] b);
        decode_t d;
        d.hit  = 1'b1;
        d.code = OP_INC;
        case (b)
            CH_PLUS:  d.code = OP_INC;
            CH_MINUS: d.code = OP_DEC;
            CH_LT:    d.code = OP_LEFT;
            CH_GT:    d.code = OP_RIGHT;
            CH_DOT:   d.code = OP_OUT;
            CH_COMMA: d.code = OP_IN;
            CH_LBRK:  d.code = OP_OPEN;
            CH_RBRK:  d.code = OP_CLOSE;
            default:  d.hit  = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// ===== hdl/bfic_regs.sv =====
// APB register file holding the cell wrap bounds.
module bfic_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bfic_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bfic_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bfic_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output bfic_pkg::cell_bounds_t           bounds
);

    logic [7:0] cell_min_reg;
    logic [7:0] cell_max_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    // Write on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_min_reg <= bfic_pkg::CELL_MIN_RST;
            cell_max_reg <= bfic_pkg::CELL_MAX_RST;
        end else if (wr_en) begin
            case (reg_sel)
                bfic_pkg::REG_CELL_MIN: cell_min_reg <= pwdata[7:0];
                bfic_pkg::REG_CELL_MAX: cell_max_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        case (reg_sel)
            bfic_pkg::REG_CELL_MIN: prdata[7:0] = cell_min_reg;
            bfic_pkg::REG_CELL_MAX: prdata[7:0] = cell_max_reg;
            default: prdata = '0;
        endcase
    end

    assign bounds.cell_min = cell_min_reg;
    assign bounds.cell_max = cell_max_reg;

endmodule

// ===== hdl/brainfuck_interpreter_core_unit.sv =====
// Top level: program loader, bracket linker and one-step instruction executor.
//
// After reset the block zeroes all TAPE_DEPTH (1024) tape cells and holds s_ready
// low; APB writes are taken during that pass. Each beat then yields exactly one
// result beat. A step beat reads the program store, jump table and tape in the
// accept cycle and does the tape write-back and counter update in the next. A load
// beat ends in S_EXEC; a closing bracket also passes S_LINK_WR and S_LINK_BACK: it
// pops the bracket stack and writes the jump table (one write port) once for each
// side of the pair. A new beat is accepted while the previous result still waits in
// the output register; the block only stalls if a second result would overwrite it.
module brainfuck_interpreter_core_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_opcode,
    input  logic [7:0]                       s_data_byte,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_out_valid,
    output logic [7:0]                       m_out_byte,
    output logic                             m_input_used,
    output logic [2:0]                       m_status,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bfic_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bfic_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bfic_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int PA_W = bfic_pkg::PA_W;
    localparam int PC_W = bfic_pkg::PC_W;
    localparam int TA_W = bfic_pkg::TA_W;
    localparam int SA_W = bfic_pkg::SA_W;
    localparam int SD_W = bfic_pkg::SD_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_LINK_WR,
        S_LINK_BACK,
        S_HOLD
    } state_t;

    bfic_pkg::cell_bounds_t bounds;

    bfic_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .bounds  (bounds)
    );

    // Control and payload registers
    state_t                state_reg,       state_next;
    logic [TA_W-1:0]       clr_cnt_reg,     clr_cnt_next;
    logic [PC_W-1:0]       len_reg,         len_next;
    logic [PC_W-1:0]       pc_reg,          pc_next;
    logic [TA_W-1:0]       tp_reg,          tp_next;
    logic [SD_W-1:0]       depth_reg,       depth_next;
    logic                  op_reg,          op_next;
    logic [7:0]            byte_reg,        byte_next;
    logic                  m_valid_reg,     m_valid_next;
    logic                  m_out_valid_reg, m_out_valid_next;
    logic [7:0]            m_out_byte_reg,  m_out_byte_next;
    logic                  m_input_used_reg, m_input_used_next;
    bfic_pkg::status_t     m_status_reg,    m_status_next;
    logic                  res_valid_reg,   res_valid_next;
    logic [7:0]            res_byte_reg,    res_byte_next;
    logic                  res_used_reg,    res_used_next;
    bfic_pkg::status_t     res_status_reg,  res_status_next;

    // Memories
    logic [2:0]            prog_mem  [bfic_pkg::PROG_DEPTH];
    logic [PA_W-1:0]       jt_mem    [bfic_pkg::PROG_DEPTH];
    logic [PA_W-1:0]       stack_mem [bfic_pkg::NEST_DEPTH];
    logic [7:0]            tape_mem  [bfic_pkg::TAPE_DEPTH];

    logic [2:0]            prog_rd_reg;
    logic [PA_W-1:0]       jt_rd_reg;
    logic [PA_W-1:0]       stack_rd_reg;
    logic [7:0]            tape_rd_reg;

    logic                  prog_we;
    logic [2:0]            prog_wd;
    logic                  jt_we;
    logic [PA_W-1:0]       jt_wa;
    logic [PA_W-1:0]       jt_wd;
    logic                  stack_we;
    logic                  stack_re;
    logic                  tape_we;
    logic [TA_W-1:0]       tape_wa;
    logic [7:0]            tape_wd;

    logic                  accept;
    logic                  out_free;
    logic                  fin;
    logic                  fin_out_valid;
    logic [7:0]            fin_out_byte;
    logic                  fin_input_used;
    bfic_pkg::status_t     fin_status;
    bfic_pkg::decode_t     dec;
    bfic_pkg::op_t         cur_op;
    logic [SD_W-1:0]       depth_dec;
    logic [7:0]            cell_val;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid & s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign dec       = bfic_pkg::decode_byte(byte_reg);
    assign cur_op    = bfic_pkg::op_t'(prog_rd_reg);
    assign depth_dec = depth_reg - SD_W'(1);
    assign cell_val  = tape_rd_reg;

    // Program store: append at len, read at pc
    always_ff @(posedge aclk) begin
        if (prog_we) begin
            prog_mem[len_reg[PA_W-1:0]] <= prog_wd;
        end
        if (accept) begin
            prog_rd_reg <= prog_mem[pc_reg[PA_W-1:0]];
        end
    end

    // Jump table: partner index of each bracket
    always_ff @(posedge aclk) begin
        if (jt_we) begin
            jt_mem[jt_wa] <= jt_wd;
        end
        if (accept) begin
            jt_rd_reg <= jt_mem[pc_reg[PA_W-1:0]];
        end
    end

    // Bracket stack: push at depth, pop from depth-1
    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[depth_reg[SA_W-1:0]] <= len_reg[PA_W-1:0];
        end
        if (stack_re) begin
            stack_rd_reg <= stack_mem[depth_dec[SA_W-1:0]];
        end
    end

    // Tape: cleared after reset, read at the pointer
    always_ff @(posedge aclk) begin
        if (tape_we) begin
            tape_mem[tape_wa] <= tape_wd;
        end
        if (accept) begin
            tape_rd_reg <= tape_mem[tp_reg];
        end
    end

    // Sequencer and datapath
    always_comb begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        len_next          = len_reg;
        pc_next           = pc_reg;
        tp_next           = tp_reg;
        depth_next        = depth_reg;
        op_next           = op_reg;
        byte_next         = byte_reg;
        res_valid_next    = res_valid_reg;
        res_byte_next     = res_byte_reg;
        res_used_next     = res_used_reg;
        res_status_next   = res_status_reg;
        m_valid_next      = m_valid_reg;
        m_out_valid_next  = m_out_valid_reg;
        m_out_byte_next   = m_out_byte_reg;
        m_input_used_next = m_input_used_reg;
        m_status_next     = m_status_reg;

        prog_we  = 1'b0;
        prog_wd  = dec.code;
        jt_we    = 1'b0;
        jt_wa    = len_reg[PA_W-1:0];
        jt_wd    = stack_rd_reg;
        stack_we = 1'b0;
        stack_re = 1'b0;
        tape_we  = 1'b0;
        tape_wa  = tp_reg;
        tape_wd  = 8'h00;

        fin            = 1'b0;
        fin_out_valid  = 1'b0;
        fin_out_byte   = 8'h00;
        fin_input_used = 1'b0;
        fin_status     = bfic_pkg::ST_OK;

        // drop the output beat once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            op_next   = s_opcode;
            byte_next = s_data_byte;
        end

        case (state_reg)
            S_CLEAR: begin
                tape_we = 1'b1;
                tape_wa = clr_cnt_reg;
                if (clr_cnt_reg == TA_W'(bfic_pkg::TAPE_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + TA_W'(1);
                end
            end

            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                if (op_reg == bfic_pkg::ITEM_LOAD) begin
                    if (!dec.hit) begin
                        fin = 1'b1;
                    end else if (len_reg >= PC_W'(bfic_pkg::PROG_DEPTH)) begin
                        fin        = 1'b1;
                        fin_status = bfic_pkg::ST_FULL;
                    end else if (dec.code == bfic_pkg::OP_OPEN &&
                                 depth_reg >= SD_W'(bfic_pkg::NEST_DEPTH)) begin
                        fin        = 1'b1;
                        fin_status = bfic_pkg::ST_NEST_OVERFLOW;
                    end else if (dec.code == bfic_pkg::OP_CLOSE && depth_reg == '0) begin
                        fin        = 1'b1;
                        fin_status = bfic_pkg::ST_UNMATCHED_CLOSE;
                    end else if (dec.code == bfic_pkg::OP_CLOSE) begin
                        // pop the partner, link both sides in S_LINK_WR and S_LINK_BACK
                        prog_we    = 1'b1;
                        stack_re   = 1'b1;
                        depth_next = depth_dec;
                        state_next = S_LINK_WR;
                    end else begin
                        prog_we  = 1'b1;
                        len_next = len_reg + PC_W'(1);
                        fin      = 1'b1;
                        if (dec.code == bfic_pkg::OP_OPEN) begin
                            stack_we   = 1'b1;
                            depth_next = depth_reg + SD_W'(1);
                        end
                    end
                end else if (depth_reg != '0) begin
                    fin        = 1'b1;
                    fin_status = bfic_pkg::ST_UNMATCHED_OPEN;
                end else if (pc_reg >= len_reg) begin
                    fin        = 1'b1;
                    fin_status = bfic_pkg::ST_HALTED;
                end else begin
                    fin     = 1'b1;
                    pc_next = pc_reg + PC_W'(1);
                    case (cur_op)
                        bfic_pkg::OP_INC: begin
                            tape_we = 1'b1;
                            tape_wd = (cell_val == bounds.cell_max) ? bounds.cell_min
                                                                    : cell_val + 8'd1;
                        end
                        bfic_pkg::OP_DEC: begin
                            tape_we = 1'b1;
                            tape_wd = (cell_val == bounds.cell_min) ? bounds.cell_max
                                                                    : cell_val - 8'd1;
                        end
                        bfic_pkg::OP_LEFT: begin
                            tp_next = (tp_reg == '0) ? TA_W'(bfic_pkg::TAPE_DEPTH - 1)
                                                     : tp_reg - TA_W'(1);
                        end
                        bfic_pkg::OP_RIGHT: begin
                            tp_next = (tp_reg >= TA_W'(bfic_pkg::TAPE_DEPTH - 1)) ? '0
                                                                : tp_reg + TA_W'(1);
                        end
                        bfic_pkg::OP_OUT: begin
                            fin_out_valid = 1'b1;
                            fin_out_byte  = cell_val;
                        end
                        bfic_pkg::OP_IN: begin
                            tape_we        = 1'b1;
                            tape_wd        = byte_reg;
                            fin_input_used = 1'b1;
                        end
                        bfic_pkg::OP_OPEN: begin
                            if (cell_val == 8'h00) begin
                                pc_next = PC_W'(jt_rd_reg) + PC_W'(1);
                            end
                        end
                        default: begin
                            if (cell_val != 8'h00) begin
                                pc_next = PC_W'(jt_rd_reg) + PC_W'(1);
                            end
                        end
                    endcase
                end
            end

            S_LINK_WR: begin
                // close bracket points back at its open
                jt_we      = 1'b1;
                jt_wa      = len_reg[PA_W-1:0];
                jt_wd      = stack_rd_reg;
                state_next = S_LINK_BACK;
            end

            S_LINK_BACK: begin
                // open bracket points forward at its close
                jt_we    = 1'b1;
                jt_wa    = stack_rd_reg;
                jt_wd    = len_reg[PA_W-1:0];
                len_next = len_reg + PC_W'(1);
                fin      = 1'b1;
            end

            S_HOLD: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_out_valid_next  = res_valid_reg;
                    m_out_byte_next   = res_byte_reg;
                    m_input_used_next = res_used_reg;
                    m_status_next     = res_status_reg;
                    state_next        = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        // hand the result to the output register, or park it
        if (fin) begin
            if (out_free) begin
                m_valid_next      = 1'b1;
                m_out_valid_next  = fin_out_valid;
                m_out_byte_next   = fin_out_byte;
                m_input_used_next = fin_input_used;
                m_status_next     = fin_status;
                state_next        = S_IDLE;
            end else begin
                res_valid_next  = fin_out_valid;
                res_byte_next   = fin_out_byte;
                res_used_next   = fin_input_used;
                res_status_next = fin_status;
                state_next      = S_HOLD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            len_reg     <= '0;
            pc_reg      <= '0;
            tp_reg      <= '0;
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            len_reg     <= len_next;
            pc_reg      <= pc_next;
            tp_reg      <= tp_next;
            depth_reg   <= depth_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg           <= op_next;
        byte_reg         <= byte_next;
        res_valid_reg    <= res_valid_next;
        res_byte_reg     <= res_byte_next;
        res_used_reg     <= res_used_next;
        res_status_reg   <= res_status_next;
        m_out_valid_reg  <= m_out_valid_next;
        m_out_byte_reg   <= m_out_byte_next;
        m_input_used_reg <= m_input_used_next;
        m_status_reg     <= m_status_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_valid  = m_out_valid_reg;
    assign m_out_byte   = m_out_byte_reg;
    assign m_input_used = m_input_used_reg;
    assign m_status     = m_status_reg;

    // The program counter never runs past the loaded program
    a_pc_in_program: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= len_reg)
        else $error("program counter beyond program length");

    // Nesting never exceeds the stack
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= SD_W'(bfic_pkg::NEST_DEPTH))
        else $error("bracket stack depth out of range");

    // The program only grows, one instruction at a time
    a_len_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (len_reg != $past(len_reg)) |->
            len_reg == $past(len_reg) + PC_W'(1))
        else $error("program length changed by more than one");

    // A result never completes while the output is still occupied by another beat
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_HOLD) && m_valid_reg && !m_ready |=> (state_reg == S_HOLD))
        else $error("parked result left before the output drained");

endmodule
